@@ hdl/stream_count_sum_min_max_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the stream count/sum/min/max block
// Each macro checks one clocked property on the rising edge. The check is
// held off while the reset is asserted.
// ----------------------------------------------------------------------------
`ifndef STREAM_COUNT_SUM_MIN_MAX_DEFINES_SVH
`define STREAM_COUNT_SUM_MIN_MAX_DEFINES_SVH

// Same-cycle implication: the consequent must hold in the cycle of the antecedent.
`define SCSMM_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: the consequent must hold in the cycle after the antecedent.
`define SCSMM_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/scsmm_pkg.sv @@
// ----------------------------------------------------------------------------
// scsmm_pkg
// Shared types and constants of the stream count/sum/min/max aggregate.
// ----------------------------------------------------------------------------
`default_nettype none

package scsmm_pkg;

  localparam int unsigned MaxLanes = 8;
  localparam int unsigned ValueW   = 64;

  // Node counts of the lane merge tree.
  localparam int unsigned L1Nodes = MaxLanes / 2;
  localparam int unsigned L2Nodes = MaxLanes / 4;

  typedef logic [ValueW-1:0] value_t;

  typedef enum logic [1:0] {
    KIND_COUNT = 2'd0,
    KIND_SUM   = 2'd1,
    KIND_MIN   = 2'd2,
    KIND_MAX   = 2'd3
  } stat_kind_e;

  // Partial aggregate of one lane, or of a group of lanes.
  typedef struct packed {
    value_t sum;
    value_t vmin;
    value_t vmax;
  } lane_acc_t;

  // Aggregate of a whole packet.
  typedef struct packed {
    value_t    count;
    lane_acc_t acc;
  } agg_t;

  // Neutral element of the lane merge.
  localparam lane_acc_t LaneAccIdentity = '{sum: '0, vmin: '1, vmax: '0};

  function automatic lane_acc_t combine_acc(lane_acc_t a, lane_acc_t b);
    lane_acc_t r;
    r.sum  = a.sum + b.sum;
    r.vmin = (b.vmin < a.vmin) ? b.vmin : a.vmin;
    r.vmax = (b.vmax > a.vmax) ? b.vmax : a.vmax;
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hdl/scsmm_if.sv @@
// ----------------------------------------------------------------------------
// scsmm stream interfaces
// Valid/ready channels for the input stream words and the result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface scsmm_in_if;
  logic              valid;
  logic              ready;
  scsmm_pkg::value_t value_0;
  scsmm_pkg::value_t value_1;
  scsmm_pkg::value_t value_2;
  scsmm_pkg::value_t value_3;
  scsmm_pkg::value_t value_4;
  scsmm_pkg::value_t value_5;
  scsmm_pkg::value_t value_6;
  scsmm_pkg::value_t value_7;
  logic              end_of_packet;

  modport source (
    output valid, value_0, value_1, value_2, value_3,
    output value_4, value_5, value_6, value_7, end_of_packet,
    input  ready
  );
  modport sink (
    input  valid, value_0, value_1, value_2, value_3,
    input  value_4, value_5, value_6, value_7, end_of_packet,
    output ready
  );
endinterface

interface scsmm_out_if;
  logic                  valid;
  logic                  ready;
  scsmm_pkg::value_t     stat_value;
  scsmm_pkg::stat_kind_e stat_kind;
  logic                  final_result;

  modport source (
    output valid, stat_value, stat_kind, final_result,
    input  ready
  );
  modport sink (
    input  valid, stat_value, stat_kind, final_result,
    output ready
  );
endinterface

`default_nettype wire

@@ hdl/scsmm_lane.sv @@
// ----------------------------------------------------------------------------
// scsmm_lane
// Per-lane accumulator: running sum, minimum and maximum of one lane.
// ----------------------------------------------------------------------------
`default_nettype none

module scsmm_lane (
  input  logic                 clk_i,
  input  logic                 load_i,
  input  logic                 fresh_i,
  input  scsmm_pkg::value_t    value_i,
  output scsmm_pkg::lane_acc_t acc_o
);
  import scsmm_pkg::*;

  lane_acc_t acc_q, acc_d;
  lane_acc_t base;

  // A fresh packet starts from the neutral element.
  always_comb begin
    base       = fresh_i ? LaneAccIdentity : acc_q;
    acc_d.sum  = base.sum + value_i;
    acc_d.vmin = (value_i < base.vmin) ? value_i : base.vmin;
    acc_d.vmax = (value_i > base.vmax) ? value_i : base.vmax;
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

`default_nettype wire

@@ hdl/scsmm_merge.sv @@
// ----------------------------------------------------------------------------
// scsmm_merge
// Three-level registered tree that merges the lane aggregates of a packet.
// ----------------------------------------------------------------------------
`default_nettype none
`include "stream_count_sum_min_max_defines.svh"

module scsmm_merge (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 snap_valid_i,
  output logic                 snap_take_o,
  input  scsmm_pkg::lane_acc_t lane_acc_i [scsmm_pkg::MaxLanes],
  input  scsmm_pkg::value_t    count_i,
  output logic                 res_valid_o,
  input  logic                 res_take_i,
  output scsmm_pkg::agg_t      res_o
);
  import scsmm_pkg::*;

  logic      v1_q, v2_q, v3_q;
  logic      v1_d, v2_d, v3_d;
  logic      en1, en2, en3;
  lane_acc_t l1_q [L1Nodes];
  lane_acc_t l2_q [L2Nodes];
  value_t    cnt1_q, cnt2_q;
  agg_t      res_q;

  // A stage loads when it is empty or its content moves on this cycle.
  assign en3 = !v3_q || res_take_i;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  assign v1_d = en1 ? snap_valid_i : v1_q;
  assign v2_d = en2 ? v1_q : v2_q;
  assign v3_d = en3 ? v2_q : v3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
      v3_q <= v3_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      for (int i = 0; i < L1Nodes; i++) begin
        l1_q[i] <= combine_acc(lane_acc_i[2*i], lane_acc_i[2*i+1]);
      end
      cnt1_q <= count_i;
    end
    if (en2) begin
      for (int i = 0; i < L2Nodes; i++) begin
        l2_q[i] <= combine_acc(l1_q[2*i], l1_q[2*i+1]);
      end
      cnt2_q <= cnt1_q;
    end
    if (en3) begin
      res_q.acc   <= combine_acc(l2_q[0], l2_q[1]);
      res_q.count <= cnt2_q;
    end
  end

  assign snap_take_o = en1;
  assign res_valid_o = v3_q;
  assign res_o       = res_q;

  `SCSMM_ASSERT_NXT(a_res_hold, clk_i, rst_ni, res_valid_o && !res_take_i, res_valid_o && $stable(res_o), "merged result changed while waiting")

endmodule

`default_nettype wire

@@ hdl/scsmm_ser.sv @@
// ----------------------------------------------------------------------------
// scsmm_ser
// Output register that issues one packet aggregate as four result transactions.
// ----------------------------------------------------------------------------
`default_nettype none
`include "stream_count_sum_min_max_defines.svh"

module scsmm_ser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              res_valid_i,
  output logic              res_take_o,
  input  scsmm_pkg::agg_t   res_i,
  scsmm_out_if.source       out_o
);
  import scsmm_pkg::*;

  logic       vo_q, vo_d;
  stat_kind_e kind_q, kind_d;
  agg_t       hold_q;
  logic       out_fire;
  logic       last_beat;

  assign out_fire  = vo_q && out_o.ready;
  assign last_beat = out_fire && (kind_q == KIND_MAX);

  // A new aggregate loads as the maximum of the previous one leaves.
  assign res_take_o = res_valid_i && (!vo_q || last_beat);

  always_comb begin
    vo_d = vo_q;
    if (res_take_o) begin
      vo_d = 1'b1;
    end else if (last_beat) begin
      vo_d = 1'b0;
    end
  end

  always_comb begin
    kind_d = kind_q;
    if (out_fire) begin
      kind_d = (kind_q == KIND_MAX) ? KIND_COUNT : stat_kind_e'(kind_q + 2'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q   <= 1'b0;
      kind_q <= KIND_COUNT;
    end else begin
      vo_q   <= vo_d;
      kind_q <= kind_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take_o) begin
      hold_q <= res_i;
    end
  end

  always_comb begin
    unique case (kind_q)
      KIND_COUNT: out_o.stat_value = hold_q.count;
      KIND_SUM:   out_o.stat_value = hold_q.acc.sum;
      KIND_MIN:   out_o.stat_value = hold_q.acc.vmin;
      KIND_MAX:   out_o.stat_value = hold_q.acc.vmax;
      default:    out_o.stat_value = hold_q.count;
    endcase
  end

  assign out_o.valid        = vo_q;
  assign out_o.stat_kind    = kind_q;
  assign out_o.final_result = (kind_q == KIND_MAX);

  `SCSMM_ASSERT_NXT(a_ser_continue, clk_i, rst_ni, out_fire && (kind_q != KIND_MAX), vo_q && (kind_q != KIND_COUNT), "result sequence broken before maximum")
  `SCSMM_ASSERT_IMP(a_ser_load_slot, clk_i, rst_ni, res_take_o, !vo_q || (kind_q == KIND_MAX), "aggregate loaded over unsent results")

endmodule

`default_nettype wire

@@ hdl/stream_count_sum_min_max.sv @@
// ----------------------------------------------------------------------------
// stream_count_sum_min_max
// Throughput: one stream word per cycle while the lane registers hold no
// packet awaiting the merge tree; the lane accumulators fold each accepted
// word. A packet's four results leave the output register at one per cycle
// while the sink is ready, so packets shorter than four words stall the input.
// Reset: asynchronous; empties the merge tree and output, next word starts
// a fresh packet. No clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none
`include "stream_count_sum_min_max_defines.svh"

module stream_count_sum_min_max #(
  parameter int unsigned LANES = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  scsmm_in_if.sink    in_i,
  scsmm_out_if.source out_o
);
  import scsmm_pkg::*;

  localparam int unsigned NLanes =
    (LANES > MaxLanes) ? MaxLanes : ((LANES < 1) ? 1 : LANES);
  localparam value_t CountStep = value_t'(NLanes);

  value_t    lane_val [MaxLanes];
  lane_acc_t lane_acc [MaxLanes];

  logic   in_fire;
  logic   fresh_q, fresh_d;
  logic   snap_q, snap_d;
  logic   snap_take;
  value_t count_q, count_d;
  logic   res_valid;
  logic   res_take;
  agg_t   res;

  assign lane_val[0] = in_i.value_0;
  assign lane_val[1] = in_i.value_1;
  assign lane_val[2] = in_i.value_2;
  assign lane_val[3] = in_i.value_3;
  assign lane_val[4] = in_i.value_4;
  assign lane_val[5] = in_i.value_5;
  assign lane_val[6] = in_i.value_6;
  assign lane_val[7] = in_i.value_7;

  // Lane registers hold a finished packet until the merge tree takes it.
  assign in_i.ready = !snap_q || snap_take;
  assign in_fire    = in_i.valid && in_i.ready;

  for (genvar g = 0; g < MaxLanes; g++) begin : g_lane
    if (g < NLanes) begin : g_used
      scsmm_lane u_lane (
        .clk_i   (clk_i),
        .load_i  (in_fire),
        .fresh_i (fresh_q),
        .value_i (lane_val[g]),
        .acc_o   (lane_acc[g])
      );
    end else begin : g_unused
      assign lane_acc[g] = LaneAccIdentity;
    end
  end

  assign count_d = (fresh_q ? '0 : count_q) + CountStep;
  assign fresh_d = in_fire ? in_i.end_of_packet : fresh_q;

  always_comb begin
    snap_d = snap_q;
    if (in_fire) begin
      snap_d = in_i.end_of_packet;
    end else if (snap_take) begin
      snap_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fresh_q <= 1'b1;
      snap_q  <= 1'b0;
    end else begin
      fresh_q <= fresh_d;
      snap_q  <= snap_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      count_q <= count_d;
    end
  end

  scsmm_merge u_merge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .snap_valid_i (snap_q),
    .snap_take_o  (snap_take),
    .lane_acc_i   (lane_acc),
    .count_i      (count_q),
    .res_valid_o  (res_valid),
    .res_take_i   (res_take),
    .res_o        (res)
  );

  scsmm_ser u_ser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_take_o  (res_take),
    .res_i       (res),
    .out_o       (out_o)
  );

  `SCSMM_ASSERT_NXT(a_eop_snapshot, clk_i, rst_ni, in_fire && in_i.end_of_packet, snap_q && fresh_q, "end of packet did not mark a snapshot")
  `SCSMM_ASSERT_NXT(a_snap_hold, clk_i, rst_ni, snap_q && !snap_take, snap_q && $stable(lane_acc[0]) && $stable(count_q), "lane snapshot overwritten before merge")

endmodule

`default_nettype wire
